[sv/assert_macros.svh]
// Assertion macros shared by the checker files.
// Each macro expects clk_i and rst_ni to be visible at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

[sv/anv_pkg.sv]
// Package for the attribute name validator: automaton states, character
// classes, request and result structs and the transition function. No dependencies.
`default_nettype none

package anv_pkg;

  localparam logic [7:0] CHAR_DOT    = 8'h2E;
  localparam logic [7:0] CHAR_SEMI   = 8'h3B;
  localparam logic [7:0] CHAR_HYPHEN = 8'h2D;

  typedef enum logic [2:0] {
    ST_START   = 3'd0,
    ST_DIGITS  = 3'd1,
    ST_DOT     = 3'd2,
    ST_KEYWORD = 3'd3,
    ST_SEMI    = 3'd4,
    ST_OPTKEY  = 3'd5,
    ST_REJECT  = 3'd6
  } state_e;

  typedef enum logic [2:0] {
    CC_DIGIT  = 3'd0,
    CC_LETTER = 3'd1,
    CC_HYPHEN = 3'd2,
    CC_DOT    = 3'd3,
    CC_SEMI   = 3'd4,
    CC_OTHER  = 3'd5
  } char_class_e;

  typedef struct packed {
    logic       valid;
    logic [7:0] char_byte;
    logic       has_byte;
    logic       last;
  } step_t;

  typedef struct packed {
    logic valid;
    logic accepted;
  } res_t;

  function automatic char_class_e classify(input logic [7:0] c);
    char_class_e cls;
    cls = CC_OTHER;
    if (c >= 8'h30 && c <= 8'h39) begin
      cls = CC_DIGIT;
    end else if ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A)) begin
      cls = CC_LETTER;
    end else if (c == CHAR_HYPHEN) begin
      cls = CC_HYPHEN;
    end else if (c == CHAR_DOT) begin
      cls = CC_DOT;
    end else if (c == CHAR_SEMI) begin
      cls = CC_SEMI;
    end
    return cls;
  endfunction

  function automatic state_e next_state(input state_e s, input char_class_e cls);
    logic   is_key;
    state_e ns;
    is_key = (cls == CC_DIGIT) || (cls == CC_LETTER) || (cls == CC_HYPHEN);
    ns     = ST_REJECT;
    case (s)
      ST_START: begin
        if (cls == CC_DIGIT) ns = ST_DIGITS;
        else if (cls == CC_LETTER) ns = ST_KEYWORD;
      end
      ST_DIGITS: begin
        if (cls == CC_DIGIT) ns = ST_DIGITS;
        else if (cls == CC_DOT) ns = ST_DOT;
        else if (cls == CC_SEMI) ns = ST_SEMI;
      end
      ST_DOT: begin
        if (cls == CC_DIGIT) ns = ST_DIGITS;
      end
      ST_KEYWORD: begin
        if (is_key) ns = ST_KEYWORD;
        else if (cls == CC_SEMI) ns = ST_SEMI;
      end
      ST_SEMI: begin
        if (is_key) ns = ST_OPTKEY;
      end
      ST_OPTKEY: begin
        if (is_key) ns = ST_OPTKEY;
        else if (cls == CC_SEMI) ns = ST_SEMI;
      end
      default: begin
        ns = ST_REJECT;
      end
    endcase
    return ns;
  endfunction

  function automatic logic is_accepting(input state_e s);
    return (s == ST_DIGITS) || (s == ST_KEYWORD) || (s == ST_OPTKEY);
  endfunction

endpackage

`default_nettype wire

[sv/anv_if.sv]
// Valid/ready channel interfaces of the attribute name validator.
// Self-contained; no package dependency.
`default_nettype none

interface anv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       has_byte;
  logic       last;

  modport source (output valid, output char_byte, output has_byte, output last,
                  input ready);
  modport sink   (input valid, input char_byte, input has_byte, input last,
                  output ready);
endinterface

interface anv_out_if;
  logic valid;
  logic ready;
  logic accepted;

  modport source (output valid, output accepted, input ready);
  modport sink   (input valid, input accepted, output ready);
endinterface

`default_nettype wire

[sv/attribute_name_validator_core.sv]
// Top level of the attribute name validator.
// Depends on anv_pkg, anv_if, anv_fsm and anv_obuf.
//
// Usage: a name enters on in_i one request per byte. char_byte is used when
// has_byte is high; a request with has_byte low carries no byte. The request
// with last high ends the name and produces exactly one result on out_o,
// where accepted is high when the name is a valid numeric identifier or
// keyword, optionally followed by options. Requests without last give no
// result. An empty name is rejected.
// Result: the verdict is registered, into the skid entry while out_o stalls.
// Throughput: one request per cycle while in_i.ready is high, set by the
// single automaton transition between the input and the result register.
// Stalls: a result waiting on out_o is held stable; one more result fits in
// a skid entry, and in_i.ready drops only while that entry is occupied.
// Reset: the automaton returns to its start state and both the result
// register and the skid entry are emptied.
`default_nettype none

module attribute_name_validator_core (
  input wire logic   clk_i,
  input wire logic   rst_ni,
  anv_in_if.sink     in_i,
  anv_out_if.source  out_o
);

  anv_pkg::step_t step;
  anv_pkg::res_t  res;
  logic           in_ready;

  always_comb begin
    step.valid     = in_i.valid && in_ready;
    step.char_byte = in_i.char_byte;
    step.has_byte  = in_i.has_byte;
    step.last      = in_i.last;
  end

  anv_fsm u_fsm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .res_o  (res)
  );

  anv_obuf u_obuf (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .res_i          (res),
    .in_ready_o     (in_ready),
    .out_valid_o    (out_o.valid),
    .out_accepted_o (out_o.accepted),
    .out_ready_i    (out_o.ready)
  );

  assign in_i.ready = in_ready;

endmodule

`default_nettype wire

[sv/anv_fsm.sv]
// Attribute name automaton: state register, per-byte transition and verdict.
// Depends on anv_pkg.
`default_nettype none

module anv_fsm (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire anv_pkg::step_t step_i,
  output anv_pkg::res_t       res_o
);

  anv_pkg::state_e state_q, state_d, stepped;

  always_comb begin
    stepped = state_q;
    if (step_i.has_byte) begin
      stepped = anv_pkg::next_state(state_q, anv_pkg::classify(step_i.char_byte));
    end
  end

  always_comb begin
    state_d = state_q;
    if (step_i.valid) begin
      state_d = step_i.last ? anv_pkg::ST_START : stepped;
    end
  end

  always_comb begin
    res_o.valid    = step_i.valid && step_i.last;
    res_o.accepted = anv_pkg::is_accepting(stepped);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= anv_pkg::ST_START;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

[sv/anv_obuf.sv]
// Result register with one skid entry between the automaton and the output.
// Depends on anv_pkg.
`default_nettype none

module anv_obuf (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire anv_pkg::res_t res_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  output logic               out_accepted_o,
  input  wire logic          out_ready_i
);

  logic out_valid_q, out_valid_d, out_acc_q, out_acc_d;
  logic skid_valid_q, skid_valid_d, skid_acc_q, skid_acc_d;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_acc_d    = out_acc_q;
    skid_valid_d = skid_valid_q;
    skid_acc_d   = skid_acc_q;
    if (out_valid_q && !out_ready_i) begin
      if (res_i.valid) begin
        skid_valid_d = 1'b1;
        skid_acc_d   = res_i.accepted;
      end
    end else if (skid_valid_q) begin
      out_valid_d  = 1'b1;
      out_acc_d    = skid_acc_q;
      skid_valid_d = res_i.valid;
      skid_acc_d   = res_i.accepted;
    end else begin
      out_valid_d = res_i.valid;
      out_acc_d   = res_i.accepted;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_acc_q  <= out_acc_d;
    skid_acc_q <= skid_acc_d;
  end

  assign in_ready_o     = !skid_valid_q;
  assign out_valid_o    = out_valid_q;
  assign out_accepted_o = out_acc_q;

endmodule

`default_nettype wire

[sv/anv_checker.sv]
// Port-level checks for attribute_name_validator_core, attached by bind.
// Depends on assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module anv_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic in_last,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic out_accepted
);

  // A fresh result only follows a taken request that ended a name.
  `ASSERT_IMPL(a_result_from_last, $rose(out_valid), $past(in_valid && in_ready && in_last))
  // Input back-pressure only happens while a result is waiting.
  `ASSERT_IMPL(a_ready_low_needs_out, !in_ready, out_valid)
  // A stalled result stays and keeps its verdict.
  `ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_accepted))

endmodule

bind attribute_name_validator_core anv_checker u_anv_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid     (in_i.valid),
  .in_ready     (in_i.ready),
  .in_last      (in_i.last),
  .out_valid    (out_o.valid),
  .out_ready    (out_o.ready),
  .out_accepted (out_o.accepted)
);

`default_nettype wire

[test/attribute_name_validator_core_tb.sv]
// Testbench for attribute_name_validator_core: streams attribute names byte by byte
// and checks each accept/reject verdict against a local model of the name automaton.
// Depends on anv_pkg, anv_if and the core RTL.
`timescale 1ns / 100ps

module attribute_name_validator_core_tb;

  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned REPORT_LIMIT = 10;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  anv_in_if  req_if ();
  anv_out_if res_if ();

  attribute_name_validator_core dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (req_if),
    .out_o  (res_if)
  );

  always #4 clk = ~clk;

  anv_pkg::state_e name_state = anv_pkg::ST_START;
  logic        verdict_q[$];
  logic [7:0]  name_buf[$];
  int unsigned src_idle_pct = 0;
  int unsigned snk_idle_pct = 0;
  int unsigned blank_pct = 0;
  int unsigned bytes_sent = 0;
  int unsigned requests_sent = 0;
  int unsigned names_accepted = 0;
  int unsigned names_rejected = 0;
  int unsigned fail_count = 0;
  int unsigned stall_left = 0;
  int unsigned quiet_cycles = 0;

  function automatic int unsigned draw_gap(input int unsigned pct);
    if ($urandom_range(99) >= pct) return 0;
    if ($urandom_range(7) == 0) return $urandom_range(40, 10);
    return $urandom_range(3, 1);
  endfunction

  function automatic anv_pkg::state_e advance_state(input anv_pkg::state_e s,
                                                    input logic [7:0] c);
    logic digit;
    logic letter;
    logic keych;
    digit  = (c >= 8'h30) && (c <= 8'h39);
    letter = ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
    keych  = digit || letter || (c == anv_pkg::CHAR_HYPHEN);
    case (s)
      anv_pkg::ST_START: begin
        if (digit) return anv_pkg::ST_DIGITS;
        if (letter) return anv_pkg::ST_KEYWORD;
      end
      anv_pkg::ST_DIGITS: begin
        if (digit) return anv_pkg::ST_DIGITS;
        if (c == anv_pkg::CHAR_DOT) return anv_pkg::ST_DOT;
        if (c == anv_pkg::CHAR_SEMI) return anv_pkg::ST_SEMI;
      end
      anv_pkg::ST_DOT: begin
        if (digit) return anv_pkg::ST_DIGITS;
      end
      anv_pkg::ST_KEYWORD: begin
        if (keych) return anv_pkg::ST_KEYWORD;
        if (c == anv_pkg::CHAR_SEMI) return anv_pkg::ST_SEMI;
      end
      anv_pkg::ST_SEMI: begin
        if (keych) return anv_pkg::ST_OPTKEY;
      end
      anv_pkg::ST_OPTKEY: begin
        if (keych) return anv_pkg::ST_OPTKEY;
        if (c == anv_pkg::CHAR_SEMI) return anv_pkg::ST_SEMI;
      end
      default: begin
      end
    endcase
    return anv_pkg::ST_REJECT;
  endfunction

  function automatic logic [7:0] rand_letter();
    if ($urandom_range(1) == 0) return 8'(8'h41 + $urandom_range(25));
    return 8'(8'h61 + $urandom_range(25));
  endfunction

  function automatic logic [7:0] rand_key_char();
    case ($urandom_range(3))
      0: return 8'(8'h30 + $urandom_range(9));
      1, 2: return rand_letter();
      default: return anv_pkg::CHAR_HYPHEN;
    endcase
  endfunction

  task automatic send_request(input logic [7:0] c, input logic hb, input logic lst);
    int unsigned gap;
    gap = draw_gap(src_idle_pct);
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid     <= 1'b1;
    req_if.char_byte <= c;
    req_if.has_byte  <= hb;
    req_if.last      <= lst;
    do @(posedge clk); while (!req_if.ready);
    requests_sent++;
    if (hb) begin
      bytes_sent++;
      name_state = advance_state(name_state, c);
    end
    if (lst) begin
      verdict_q.push_back((name_state == anv_pkg::ST_DIGITS) ||
                          (name_state == anv_pkg::ST_KEYWORD) ||
                          (name_state == anv_pkg::ST_OPTKEY));
      name_state = anv_pkg::ST_START;
    end
  endtask

  task automatic send_name(input bit empty_end);
    for (int i = 0; i < name_buf.size(); i++) begin
      if ($urandom_range(99) < blank_pct) send_request(8'($urandom_range(255)), 1'b0, 1'b0);
      send_request(name_buf[i], 1'b1, (i == name_buf.size() - 1) && !empty_end);
    end
    if (empty_end || name_buf.size() == 0) send_request(8'($urandom_range(255)), 1'b0, 1'b1);
  endtask

  task automatic send_text(input string s);
    name_buf.delete();
    for (int i = 0; i < s.len(); i++) name_buf.push_back(s[i]);
    send_name(1'b0);
  endtask

  task automatic build_name();
    int unsigned runs;
    int unsigned len;
    int unsigned opts;
    int unsigned pos;
    logic [7:0]  odd;
    name_buf.delete();
    if ($urandom_range(1) == 0) begin
      runs = $urandom_range(4, 1);
      for (int r = 0; r < runs; r++) begin
        if (r != 0) name_buf.push_back(anv_pkg::CHAR_DOT);
        len = $urandom_range(3, 1);
        repeat (len) name_buf.push_back(8'(8'h30 + $urandom_range(9)));
      end
    end else begin
      name_buf.push_back(rand_letter());
      len = $urandom_range(6);
      repeat (len) name_buf.push_back(rand_key_char());
    end
    opts = ($urandom_range(2) == 0) ? $urandom_range(2, 1) : 0;
    repeat (opts) begin
      name_buf.push_back(anv_pkg::CHAR_SEMI);
      len = $urandom_range(4, 1);
      repeat (len) name_buf.push_back(rand_key_char());
    end
    if ($urandom_range(99) < 30) begin
      pos = $urandom_range(name_buf.size() - 1);
      case ($urandom_range(3))
        0: name_buf[pos] = 8'($urandom_range(255));
        1: name_buf.push_back(($urandom_range(1) == 0) ? anv_pkg::CHAR_DOT
                                                       : anv_pkg::CHAR_SEMI);
        2: name_buf.insert(pos, anv_pkg::CHAR_DOT);
        default: begin
          case ($urandom_range(7))
            0: odd = 8'h2F;
            1: odd = 8'h3A;
            2: odd = 8'h40;
            3: odd = 8'h5B;
            4: odd = 8'h60;
            5: odd = 8'h7B;
            6: odd = 8'h20;
            default: odd = 8'h2C;
          endcase
          name_buf.insert(pos, odd);
        end
      endcase
    end
  endtask

  task automatic wait_all_verdicts();
    req_if.valid <= 1'b0;
    do @(posedge clk); while (verdict_q.size() != 0);
  endtask

  task automatic test_directed();
    src_idle_pct = 0;
    snk_idle_pct = 0;
    blank_pct = 0;
    send_request(8'hFF, 1'b0, 1'b1);
    send_text("09.1");
    send_text("Za-z;A");
    send_text("1.");
    send_text("k;");
    send_text("1;o");
    send_request(8'h00, 1'b1, 1'b0);
    send_request(8'hFF, 1'b0, 1'b0);
    send_request(8'h41, 1'b1, 1'b1);
    send_request(8'hFF, 1'b1, 1'b1);
    send_request(8'h78, 1'b1, 1'b0);
    send_request(8'h00, 1'b0, 1'b1);
  endtask

  task automatic test_streaming();
    int unsigned goal;
    src_idle_pct = 0;
    snk_idle_pct = 0;
    blank_pct = 5;
    goal = bytes_sent + 200;
    while (bytes_sent < goal) begin
      build_name();
      send_name($urandom_range(99) < 15);
    end
  endtask

  task automatic test_result_stalls();
    int unsigned goal;
    src_idle_pct = 0;
    snk_idle_pct = 70;
    blank_pct = 0;
    goal = bytes_sent + 150;
    while (bytes_sent < goal) begin
      name_buf.delete();
      name_buf.push_back(($urandom_range(3) == 0) ? 8'($urandom_range(255)) : rand_key_char());
      send_name($urandom_range(99) < 10);
    end
  endtask

  task automatic test_drain_pauses();
    src_idle_pct = 20;
    snk_idle_pct = 40;
    blank_pct = 10;
    repeat (4) begin
      repeat (4) begin
        build_name();
        send_name($urandom_range(99) < 15);
      end
      wait_all_verdicts();
    end
  endtask

  task automatic test_random_names();
    int unsigned goal;
    int unsigned count;
    goal = bytes_sent + 900;
    count = 0;
    blank_pct = 8;
    while (bytes_sent < goal) begin
      if (count % 40 == 0) begin
        case ($urandom_range(3))
          0: src_idle_pct = 0;
          1: src_idle_pct = 20;
          default: src_idle_pct = 50;
        endcase
        case ($urandom_range(3))
          0: snk_idle_pct = 0;
          1: snk_idle_pct = 20;
          default: snk_idle_pct = 50;
        endcase
      end
      if ($urandom_range(99) < 3) name_buf.delete();
      else build_name();
      send_name($urandom_range(99) < 15);
      count++;
    end
  endtask

  initial begin
    logic want;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && res_if.valid && res_if.ready) begin
        if (verdict_q.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT)
            $display("Unexpected verdict %0b with no name pending", res_if.accepted);
        end else begin
          want = verdict_q.pop_front();
          if (want) names_accepted++;
          else names_rejected++;
          if (res_if.accepted !== want) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
              $display("Verdict mismatch: expected %0b, got %0b", want, res_if.accepted);
          end
        end
      end
      if (stall_left != 0) begin
        stall_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
        stall_left = draw_gap(snk_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles == STALL_LIMIT) begin
          $display("Timeout: no progress for %0d cycles", STALL_LIMIT);
          $display("attribute_name_validator_core_tb NOT OK");
          $finish;
        end
      end
    end
  end

  initial begin
    req_if.valid     <= 1'b0;
    req_if.char_byte <= 8'h00;
    req_if.has_byte  <= 1'b0;
    req_if.last      <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_streaming();
    test_result_stalls();
    test_drain_pauses();
    test_random_names();
    wait_all_verdicts();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d requests carrying %0d name bytes.", requests_sent, bytes_sent);
    $display("Checked %0d verdicts: %0d accepted, %0d rejected, %0d failures.",
             names_accepted + names_rejected, names_accepted, names_rejected, fail_count);
    if (fail_count == 0 && verdict_q.size() == 0) begin
      $display("attribute_name_validator_core_tb OK");
    end else begin
      $display("attribute_name_validator_core_tb NOT OK");
    end
    $finish;
  end

endmodule
